[sv/rcr_pkg.sv]
package rcr_pkg;

  // Default texture geometry
  localparam int TEX_WIDTH_DEF  = 64;
  localparam int TEX_HEIGHT_DEF = 64;
  localparam int WALL_COUNT     = 4;

  // Texture store: four walls of 4096 texels
  localparam int TEX_IDX_W = 12;
  localparam int WALL_W    = 2;
  localparam int MEM_AW    = WALL_W + TEX_IDX_W;
  localparam int MEM_DEPTH = WALL_COUNT << TEX_IDX_W;
  // Texture column holds values below TEX_WIDTH, at most 255
  localparam int TEX_COL_W = 8;

  // Shared divider geometry
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 36;

  // Angles in 1/16 degree
  localparam logic [12:0] ANG_TURN  = 13'd5760;
  localparam logic [12:0] ANG_QUART = 13'd1440;
  localparam logic [12:0] ANG_HALF  = 13'd2880;
  localparam logic [12:0] ANG_3QUART = 13'd4320;
  localparam logic [23:0] BH_CONST  = 24'd10368000;

  localparam logic signed [31:0] DIST_MIN = -32'sd6553;
  localparam logic [30:0]        COL_SAT  = 31'h4000_0000;
  localparam logic [12:0]        SPAN_MAX = 13'd8191;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_SKY   = 2'd1,
    PH_WALL  = 2'd2,
    PH_FLOOR = 2'd3
  } span_phase_t;

  typedef enum logic [1:0] {
    K_TEXEL = 2'd0,
    K_START = 2'd1,
    K_STEP  = 2'd2,
    K_NONE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    DOP_COS  = 2'd0,
    DOP_WALL = 2'd1,
    DOP_STEP = 2'd2,
    DOP_ROW  = 2'd3
  } div_op_t;

  typedef enum logic [2:0] {
    R_WIDTH  = 3'd0,
    R_HEIGHT = 3'd1,
    R_VIEW   = 3'd2,
    R_SKY    = 3'd3,
    R_FLOOR  = 3'd4
  } reg_idx_t;

  typedef enum logic [3:0] {
    CS_IDLE,
    CS_PIX,
    CS_PREP,
    CS_COS,
    CS_MUL,
    CS_QUOT,
    CS_DIVC,
    CS_SPAN,
    CS_STEPW,
    CS_ROWGO,
    CS_ROWW,
    CS_FIN
  } ctl_state_t;

  typedef struct packed {
    logic [12:0] width;
    logic [12:0] height;
    logic [12:0] view;
    logic [31:0] sky;
    logic [31:0] floor_c;
  } cfg_t;

  typedef struct packed {
    logic    tex_we;
    logic    ray_ld;
    logic    step;
    logic    pix_ld;
    logic    prep;
    logic    div_start;
    div_op_t div_op;
    logic    div_cap;
    logic    mul;
    logic    quot;
    logic    span;
    logic    fin;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic phase_idle;
    logic out_free;
  } stat_t;

endpackage

[sv/raycast_column_renderer_unit.sv]
// Wall column renderer for a raycaster. Kind 0 items write one texel of four 4096-texel wall
// textures. Kind 1 items set up a column: the ray's nearer hit, its face and texture column, a
// fisheye-corrected distance and the wall height. Setup runs four divisions through one shared
// 48-step restoring divider, and no item is taken until setup is done. While a column is in
// progress, kind 2 items each give one pixel, sky, textured wall or floor, top to bottom: the
// texture memory read is registered, then the output register is loaded once it is free; the
// next item is taken while a pixel waits on the master side. The user must write configuration
// over the APB port only while the block is idle; the block itself does not enforce this.
module raycast_column_renderer_unit #(
  parameter int TEX_WIDTH  = rcr_pkg::TEX_WIDTH_DEF,
  parameter int TEX_HEIGHT = rcr_pkg::TEX_HEIGHT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // tdata: column[11:0], hor_distance[43:12], ver_distance[75:44], hor_hit_frac[91:76],
  // ver_hit_frac[107:92], ray_angle[120:108], texel_wall[122:121], texel_index[134:123],
  // texel_color[166:135], zero pad[167]
  input  logic [167:0] s_tdata,
  // tuser: kind[1:0]
  input  logic [1:0]   s_tuser,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: pixel_address[23:0], pixel_color[55:24]
  output logic [55:0]  m_tdata,
  output logic         m_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import rcr_pkg::*;

  cfg_t                cfg;
  cmd_t                cmd;
  stat_t               st;
  logic                div_done;
  logic [DIV_NW-1:0]   div_quo, div_num;
  logic [DIV_DW-1:0]   div_den;
  logic [23:0]         out_addr;
  logic [31:0]         out_color;

  rcr_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  rcr_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (s_tvalid),
    .in_kind  (kind_t'(s_tuser)),
    .st,
    .in_ready (s_tready),
    .cmd
  );

  rcr_div u_div (
    .clk, .rst,
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  rcr_dp #(.TEX_WIDTH(TEX_WIDTH), .TEX_HEIGHT(TEX_HEIGHT)) u_dp (
    .clk, .rst, .cfg, .cmd,
    .column       (s_tdata[11:0]),
    .hor_distance ($signed(s_tdata[43:12])),
    .ver_distance ($signed(s_tdata[75:44])),
    .hor_hit_frac (s_tdata[91:76]),
    .ver_hit_frac (s_tdata[107:92]),
    .ray_angle    (s_tdata[120:108]),
    .texel_wall   (s_tdata[122:121]),
    .texel_index  (s_tdata[134:123]),
    .texel_color  (s_tdata[166:135]),
    .div_done, .div_quo, .div_num, .div_den, .st,
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_addr,
    .out_color,
    .out_last     (m_tlast)
  );

  assign m_tdata = {out_color, out_addr};

  // A quotient arrives only while the controller waits for one
  a_div_wait: assert property (@(posedge clk) disable iff (rst) st.div_done |-> cmd.div_cap)
    else $error("divider finished outside a wait state");

  // Column setup holds off the input side
  a_setup_busy: assert property (@(posedge clk) disable iff (rst) cmd.ray_ld |=> !s_tready)
    else $error("input taken during column setup");

  // A new pixel appears only after a load
  a_pix_load: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(cmd.pix_ld))
    else $error("output valid without pixel load");

endmodule

[sv/rcr_regs.sv]
module rcr_regs (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output rcr_pkg::cfg_t     cfg
);
  import rcr_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  // Write registers on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.width   <= 13'd640;
      cfg.height  <= 13'd480;
      cfg.view    <= 13'd0;
      cfg.sky     <= 32'd0;
      cfg.floor_c <= 32'd0;
    end else if (wr) begin
      unique case (idx)
        R_WIDTH:  cfg.width   <= pwdata[12:0];
        R_HEIGHT: cfg.height  <= pwdata[12:0];
        R_VIEW:   cfg.view    <= pwdata[12:0];
        R_SKY:    cfg.sky     <= pwdata;
        R_FLOOR:  cfg.floor_c <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (idx)
      R_WIDTH:  prdata = {19'd0, cfg.width};
      R_HEIGHT: prdata = {19'd0, cfg.height};
      R_VIEW:   prdata = {19'd0, cfg.view};
      R_SKY:    prdata = cfg.sky;
      R_FLOOR:  prdata = cfg.floor_c;
      default:  prdata = 32'd0;
    endcase
  end

endmodule

[sv/rcr_div.sv]
module rcr_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [rcr_pkg::DIV_NW-1:0] num,
  input  logic [rcr_pkg::DIV_DW-1:0] den,
  output logic                       done,
  output logic [rcr_pkg::DIV_NW-1:0] quo
);
  import rcr_pkg::*;

  localparam int CW = $clog2(DIV_NW);

  logic [DIV_NW-1:0] n_r;
  logic [DIV_DW-1:0] r_r;
  logic [DIV_DW-1:0] den_r;
  logic [CW-1:0]     cnt;
  logic              busy;
  logic [DIV_DW:0]   shifted;
  logic [DIV_DW:0]   trial;

  assign shifted = {r_r, n_r[DIV_NW-1]};
  assign trial   = shifted - {1'b0, den_r};
  assign quo     = n_r;

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        n_r   <= num;
        r_r   <= '0;
        den_r <= den;
        cnt   <= CW'(DIV_NW - 1);
        busy  <= 1'b1;
      end else if (busy) begin
        if (!trial[DIV_DW]) begin
          r_r <= trial[DIV_DW-1:0];
          n_r <= {n_r[DIV_NW-2:0], 1'b1};
        end else begin
          r_r <= shifted[DIV_DW-1:0];
          n_r <= {n_r[DIV_NW-2:0], 1'b0};
        end
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

endmodule

[sv/rcr_ctrl.sv]
module rcr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  rcr_pkg::kind_t  in_kind,
  input  rcr_pkg::stat_t  st,
  output logic            in_ready,
  output rcr_pkg::cmd_t   cmd
);
  import rcr_pkg::*;

  ctl_state_t state, state_next;
  logic       acc;

  assign acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) state <= CS_IDLE;
    else     state <= state_next;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      CS_IDLE: begin
        if (acc && in_kind == K_START) state_next = CS_PREP;
        else if (acc && in_kind == K_STEP && !st.phase_idle) state_next = CS_PIX;
      end
      CS_PIX:   if (st.out_free) state_next = CS_IDLE;
      CS_PREP:  state_next = CS_COS;
      CS_COS:   if (st.div_done) state_next = CS_MUL;
      CS_MUL:   state_next = CS_QUOT;
      CS_QUOT:  state_next = CS_DIVC;
      CS_DIVC:  if (st.div_done) state_next = CS_SPAN;
      CS_SPAN:  state_next = CS_STEPW;
      CS_STEPW: if (st.div_done) state_next = CS_ROWGO;
      CS_ROWGO: state_next = CS_ROWW;
      CS_ROWW:  if (st.div_done) state_next = CS_FIN;
      CS_FIN:   state_next = CS_IDLE;
      default:  state_next = CS_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      CS_IDLE: begin
        in_ready   = 1'b1;
        cmd.tex_we = acc && in_kind == K_TEXEL;
        cmd.ray_ld = acc && in_kind == K_START;
        cmd.step   = acc && in_kind == K_STEP && !st.phase_idle;
      end
      CS_PIX:   cmd.pix_ld = st.out_free;
      CS_PREP: begin
        cmd.prep      = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_op    = DOP_COS;
      end
      CS_COS: begin
        cmd.div_op  = DOP_COS;
        cmd.div_cap = 1'b1;
      end
      CS_MUL:   cmd.mul = 1'b1;
      CS_QUOT: begin
        cmd.quot      = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_op    = DOP_WALL;
      end
      CS_DIVC: begin
        cmd.div_op  = DOP_WALL;
        cmd.div_cap = 1'b1;
      end
      CS_SPAN: begin
        cmd.span      = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_op    = DOP_STEP;
      end
      CS_STEPW: begin
        cmd.div_op  = DOP_STEP;
        cmd.div_cap = 1'b1;
      end
      CS_ROWGO: begin
        cmd.div_start = 1'b1;
        cmd.div_op    = DOP_ROW;
      end
      CS_ROWW: begin
        cmd.div_op  = DOP_ROW;
        cmd.div_cap = 1'b1;
      end
      CS_FIN:   cmd.fin = 1'b1;
      default: ;
    endcase
  end

endmodule

[sv/rcr_dp.sv]
module rcr_dp #(
  parameter int TEX_WIDTH  = rcr_pkg::TEX_WIDTH_DEF,
  parameter int TEX_HEIGHT = rcr_pkg::TEX_HEIGHT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rcr_pkg::cfg_t                cfg,
  input  rcr_pkg::cmd_t                cmd,
  input  logic [11:0]                  column,
  input  logic signed [31:0]           hor_distance,
  input  logic signed [31:0]           ver_distance,
  input  logic [15:0]                  hor_hit_frac,
  input  logic [15:0]                  ver_hit_frac,
  input  logic [12:0]                  ray_angle,
  input  logic [1:0]                   texel_wall,
  input  logic [11:0]                  texel_index,
  input  logic [31:0]                  texel_color,
  input  logic                         div_done,
  input  logic [rcr_pkg::DIV_NW-1:0]   div_quo,
  output logic [rcr_pkg::DIV_NW-1:0]   div_num,
  output logic [rcr_pkg::DIV_DW-1:0]   div_den,
  output rcr_pkg::stat_t               st,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic [23:0]                  out_addr,
  output logic [31:0]                  out_color,
  output logic                         out_last
);
  import rcr_pkg::*;

  typedef struct packed {
    span_phase_t ph;
    logic [12:0] rem;
  } span_t;

  // Advance past empty spans
  function automatic span_t settle(span_t s, logic [12:0] wl, logic [12:0] sl);
    span_t r;
    r = s;
    for (int i = 0; i < 3; i++) begin
      if (r.ph != PH_IDLE && r.rem == 13'd0) begin
        unique case (r.ph)
          PH_SKY: begin
            r.ph  = PH_WALL;
            r.rem = wl;
          end
          PH_WALL: begin
            r.ph  = PH_FLOOR;
            r.rem = sl;
          end
          default: r.ph = PH_IDLE;
        endcase
      end
    end
    return r;
  endfunction

  logic [31:0] mem [MEM_DEPTH];
  logic [31:0] mem_q;

  // Latched ray
  logic [11:0]        col_r;
  logic signed [31:0] hor_r, ver_r;
  logic [15:0]        hfrac_r, vfrac_r;
  logic [12:0]        ang_r;

  // Column setup
  logic                 cneg_r;
  logic signed [31:0]   dist_r;
  logic signed [17:0]   cos_r;
  logic signed [49:0]   p_r;
  logic                 q_zero_r, q_neg_r;
  logic signed [31:0]   c_r;
  logic [14:0]          len_r;
  logic [31:0]          acc0_unused;

  // Column state
  span_phase_t          phase;
  logic [12:0]          rem;
  logic [23:0]          next_address;
  logic [1:0]           face_r;
  logic [TEX_COL_W-1:0] tcol_r;
  logic [31:0]          acc_r, step_r;
  logic [12:0]          sky_len_r, wall_len_r;

  // Pending pixel
  span_phase_t          pend_phase;
  logic [23:0]          pend_addr;
  logic                 pend_last;

  // Cosine operands from the latched angle
  logic [12:0] diff, dm, s;
  logic [13:0] s0;
  logic        cneg;
  logic [11:0] x;
  logic [23:0] t;

  always_comb begin
    diff = (cfg.view >= ang_r) ? cfg.view - ang_r : ang_r - cfg.view;
    dm   = (diff >= ANG_TURN) ? diff - ANG_TURN : diff;
    s0   = {1'b0, dm} + {1'b0, ANG_QUART};
    s    = (s0 >= {1'b0, ANG_TURN}) ? 13'(s0 - {1'b0, ANG_TURN}) : s0[12:0];
    cneg = s >= ANG_HALF;
    x    = cneg ? 12'(s - ANG_HALF) : s[11:0];
    t    = 24'(x) * 24'(ANG_HALF[11:0] - x);
  end

  // Corrected distance, truncated toward zero
  logic signed [49:0] pb;
  logic signed [33:0] q_c;
  logic [33:0]        qmag;

  always_comb begin
    pb   = p_r + (p_r[49] ? 50'sd65535 : 50'sd0);
    q_c  = pb[49:16];
    qmag = q_c[33] ? 34'(-q_c) : 34'(q_c);
  end

  // Spans from the wall height
  logic [14:0]        len_c;
  logic signed [32:0] sky_v;
  logic [15:0]        sky_q;
  logic [12:0]        sky_c;
  logic [14:0]        h15, dlen;

  always_comb begin
    len_c = (c_r > 32'sd0) ? c_r[30:16] : 15'd0;
    sky_v = $signed({4'd0, cfg.height, 16'd0}) - 33'(c_r);
    sky_q = sky_v[32:17];
    if (sky_v[32])               sky_c = 13'd0;
    else if (sky_q > 16'(SPAN_MAX)) sky_c = SPAN_MAX;
    else                         sky_c = sky_q[12:0];
    h15  = {2'd0, cfg.height};
    dlen = len_r - h15;
  end

  // Divider operand select
  always_comb begin
    unique case (cmd.div_op)
      DOP_COS: begin
        div_num = DIV_NW'(t) << 18;
        div_den = DIV_DW'(BH_CONST - t);
      end
      DOP_WALL: begin
        div_num = {1'b0, cfg.height, 34'd0};
        div_den = (DIV_DW'(qmag) << 2) + DIV_DW'(qmag);
      end
      DOP_STEP: begin
        div_num = DIV_NW'(TEX_HEIGHT) << 16;
        div_den = DIV_DW'(len_c);
      end
      default: begin
        div_num = (DIV_NW'(dlen) * DIV_NW'(TEX_HEIGHT)) << 16;
        div_den = DIV_DW'({len_r, 1'b0});
      end
    endcase
  end

  // Wall height with saturation
  logic [30:0] c_mag;
  assign c_mag = (div_quo > DIV_NW'(COL_SAT)) ? COL_SAT : div_quo[30:0];

  // Texel address of the current wall row
  logic [11:0]        row;
  logic [19:0]        row_off;
  logic [11:0]        tidx;
  logic [MEM_AW-1:0]  rd_addr;

  always_comb begin
    row     = acc_r[27:16];
    row_off = 20'(row) * 20'(TEX_WIDTH);
    tidx    = 12'(tcol_r) + row_off[11:0];
    rd_addr = {face_r, tidx};
  end

  // Step pixel advance
  span_t step_in, step_out, start_out;
  always_comb begin
    step_in.ph     = phase;
    step_in.rem    = rem - 13'd1;
    step_out       = settle(step_in, wall_len_r, sky_len_r);
    start_out      = settle(span_t'({PH_SKY, sky_len_r}), wall_len_r, sky_len_r);
  end

  // Texture memory
  always_ff @(posedge clk) begin
    if (cmd.tex_we) mem[{texel_wall, texel_index}] <= texel_color;
    if (cmd.step)   mem_q <= mem[rd_addr];
  end

  // Ray setup
  logic [24:0] tcol_p;
  assign tcol_p = 25'(hor_r < ver_r ? hfrac_r : vfrac_r) * 25'(TEX_WIDTH);
  assign acc0_unused = div_quo[31:0];

  always_ff @(posedge clk) begin
    if (cmd.ray_ld) begin
      col_r   <= column;
      hor_r   <= hor_distance;
      ver_r   <= ver_distance;
      hfrac_r <= hor_hit_frac;
      vfrac_r <= ver_hit_frac;
      ang_r   <= ray_angle;
    end
    if (cmd.prep) begin
      cneg_r <= cneg;
      dist_r <= (hor_r < ver_r && hor_r >= DIST_MIN) ? hor_r : ver_r;
      if (ver_r < hor_r) face_r <= (ang_r > ANG_QUART && ang_r < ANG_3QUART) ? 2'd3 : 2'd2;
      else               face_r <= (ang_r > ANG_HALF) ? 2'd1 : 2'd0;
      tcol_r <= tcol_p[16 +: TEX_COL_W];
    end
    if (cmd.mul) p_r <= dist_r * cos_r;
    if (cmd.quot) begin
      q_zero_r <= q_c == 34'sd0;
      q_neg_r  <= q_c[33];
    end
    if (cmd.span) begin
      sky_len_r <= sky_c;
      len_r     <= len_c;
    end
    if (cmd.div_cap && div_done) begin
      unique case (cmd.div_op)
        DOP_COS:  cos_r <= cneg_r ? -$signed({1'b0, div_quo[16:0]})
                                  :  $signed({1'b0, div_quo[16:0]});
        DOP_WALL: begin
          if (q_zero_r)     c_r <= $signed({1'b0, COL_SAT});
          else if (q_neg_r) c_r <= -$signed({1'b0, c_mag});
          else              c_r <= $signed({1'b0, c_mag});
        end
        DOP_STEP: step_r <= (len_r == 15'd0) ? 32'd0 : acc0_unused;
        default: begin
          if (len_r > h15) begin
            acc_r      <= acc0_unused;
            wall_len_r <= (cfg.height == 13'd0) ? 13'd0 : cfg.height - 13'd1;
          end else begin
            acc_r      <= 32'd0;
            wall_len_r <= len_r[12:0];
          end
        end
      endcase
    end
    if (cmd.step) begin
      pend_phase <= phase;
      pend_addr  <= next_address;
      pend_last  <= step_out.ph == PH_IDLE;
      if (phase == PH_WALL) acc_r <= acc_r + step_r;
    end
  end

  // Span control
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      rem          <= 13'd0;
      next_address <= 24'd0;
    end else if (cmd.fin) begin
      phase        <= start_out.ph;
      rem          <= start_out.rem;
      next_address <= 24'(col_r);
    end else if (cmd.step) begin
      phase        <= step_out.ph;
      rem          <= step_out.rem;
      next_address <= next_address + 24'(cfg.width);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.pix_ld) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.pix_ld) begin
      out_addr <= pend_addr;
      out_last <= pend_last;
      unique case (pend_phase)
        PH_SKY:   out_color <= cfg.sky;
        PH_FLOOR: out_color <= cfg.floor_c;
        default:  out_color <= mem_q;
      endcase
    end
  end

  assign st.div_done   = div_done;
  assign st.phase_idle = phase == PH_IDLE;
  assign st.out_free   = !out_valid || out_ready;

endmodule
